// ===== rtl/vmc_pkg.sv =====
package vmc_pkg;

  // field widths
  localparam int CompW = 16;
  localparam int LimW  = 15;
  localparam int SqW   = 2 * CompW;
  localparam int NumW  = CompW + LimW;
  localparam int RemW  = CompW + 2;

  // register indexes
  typedef enum logic {
    RegVelocity = 1'b0,
    RegAccel    = 1'b1
  } vmc_reg_e;

  // input and result words
  typedef struct packed {
    logic                    command;
    logic signed [CompW-1:0] comp_x;
    logic signed [CompW-1:0] comp_y;
    logic signed [CompW-1:0] comp_z;
  } vmc_in_t;

  typedef struct packed {
    logic signed [CompW-1:0] out_x;
    logic signed [CompW-1:0] out_y;
    logic signed [CompW-1:0] out_z;
    logic                    was_clamped;
  } vmc_out_t;

  // per-item data that rides along the pipeline
  typedef struct packed {
    logic                       clamp;
    logic [2:0]                 neg;
    logic [2:0][CompW-1:0]      raw;
    logic [2:0][NumW-1:0]       num;
  } vmc_side_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [CompW-1:0] root;
  } vmc_sq_t;

  typedef struct packed {
    logic [CompW-1:0] rem;
    logic [CompW-1:0] dq;
  } vmc_dv_t;

  // one root digit: shift in two radicand bits, try (root << 2) | 1
  function automatic vmc_sq_t sqrt_step(vmc_sq_t s, logic [1:0] pair);
    logic [RemW-1:0] r2;
    logic [RemW-1:0] trial;
    vmc_sq_t         n;
    r2    = {s.rem[RemW-3:0], pair};
    trial = {s.root, 2'b01};
    if (r2 >= trial) begin
      n.rem  = r2 - trial;
      n.root = {s.root[CompW-2:0], 1'b1};
    end else begin
      n.rem  = r2;
      n.root = {s.root[CompW-2:0], 1'b0};
    end
    return n;
  endfunction

  // one quotient bit of restoring division; dividend bits shift out of dq
  function automatic vmc_dv_t div_step(vmc_dv_t s, logic [CompW-1:0] dvsr);
    logic [CompW:0]   r2;
    logic [CompW:0]   diff;
    vmc_dv_t          n;
    r2   = {s.rem, s.dq[CompW-1]};
    diff = r2 - {1'b0, dvsr};
    if (r2 >= {1'b0, dvsr}) begin
      n.rem = diff[CompW-1:0];
      n.dq  = {s.dq[CompW-2:0], 1'b1};
    end else begin
      n.rem = r2[CompW-1:0];
      n.dq  = {s.dq[CompW-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// ===== rtl/vmc_front.sv =====
module vmc_front import vmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  vmc_in_t          in_i,
  input  logic [LimW-1:0]  lim_i,
  output logic             vld_o,
  output logic [SqW-1:0]   sq_o,
  output vmc_side_t        side_o
);

  logic [2:0][CompW-1:0] comp;
  logic [2:0][CompW-1:0] mag;
  logic [2:0]            neg;

  logic                  vld_a_q;
  logic [2:0][SqW-1:0]   sqp_q;
  logic [2*LimW-1:0]     limsq_q;
  vmc_side_t             side_a_q;
  logic                  vld_b_q;
  logic [SqW-1:0]        sq_q;
  vmc_side_t             side_b_d;
  vmc_side_t             side_b_q;
  logic [SqW-1:0]        sq_sum;

  // sign and magnitude of each component
  always_comb begin
    comp = {in_i.comp_x, in_i.comp_y, in_i.comp_z};
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i][CompW-1];
      mag[i] = neg[i] ? (~comp[i] + 1'b1) : comp[i];
    end
  end

  // stage A: squares, scaled numerators, squared limit
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sqp_q[i]        <= SqW'(mag[i] * mag[i]);
      side_a_q.num[i] <= NumW'(mag[i] * lim_i);
    end
    limsq_q        <= (2*LimW)'(lim_i * lim_i);
    side_a_q.neg   <= neg;
    side_a_q.raw   <= comp;
    side_a_q.clamp <= 1'b0;
  end

  // stage B: squared norm and limit compare
  assign sq_sum = sqp_q[0] + sqp_q[1] + sqp_q[2];

  always_comb begin
    side_b_d       = side_a_q;
    side_b_d.clamp = sq_sum > SqW'(limsq_q);
  end

  always_ff @(posedge clk_i) begin
    sq_q     <= sq_sum;
    side_b_q <= side_b_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  assign vld_o  = vld_b_q;
  assign sq_o   = sq_q;
  assign side_o = side_b_q;

endmodule

// ===== rtl/vmc_sqrt_pipe.sv =====
module vmc_sqrt_pipe import vmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [SqW-1:0]   sq_i,
  input  vmc_side_t        side_i,
  output logic             vld_o,
  output logic [CompW-1:0] root_o,
  output vmc_side_t        side_o
);

  // one root bit per stage
  logic      [CompW:1] vld_q;
  vmc_sq_t             st_q   [1:CompW];
  logic [SqW-1:0]      rad_q  [1:CompW];
  vmc_side_t           side_q [1:CompW];

  vmc_sq_t             st_c   [0:CompW-1];
  logic [SqW-1:0]      rad_c  [0:CompW-1];
  vmc_side_t           side_c [0:CompW-1];

  always_comb begin
    st_c[0]   = '0;
    rad_c[0]  = sq_i;
    side_c[0] = side_i;
    for (int s = 1; s < CompW; s++) begin
      st_c[s]   = st_q[s];
      rad_c[s]  = rad_q[s];
      side_c[s] = side_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < CompW; s++) begin
      st_q[s+1]   <= sqrt_step(st_c[s], rad_c[s][SqW-1:SqW-2]);
      rad_q[s+1]  <= {rad_c[s][SqW-3:0], 2'b00};
      side_q[s+1] <= side_c[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CompW-1:1], vld_i};
    end
  end

  assign vld_o  = vld_q[CompW];
  assign root_o = st_q[CompW].root;
  assign side_o = side_q[CompW];

endmodule

// ===== rtl/vmc_div_pipe.sv =====
module vmc_div_pipe import vmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [CompW-1:0] norm_i,
  input  vmc_side_t        side_i,
  output logic             vld_o,
  output vmc_out_t         out_o
);

  // three lanes, one quotient bit per stage
  logic      [CompW:1]  vld_q;
  vmc_dv_t [2:0]        st_q   [1:CompW];
  logic [CompW-1:0]     norm_q [1:CompW];
  vmc_side_t            side_q [1:CompW];

  vmc_dv_t [2:0]        st_c   [0:CompW-1];
  logic [CompW-1:0]     norm_c [0:CompW-1];
  vmc_side_t            side_c [0:CompW-1];

  logic                 vld_out_q;
  vmc_out_t             out_q;
  logic [2:0][CompW-1:0] res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      st_c[0][i].rem = CompW'(side_i.num[i] >> CompW);
      st_c[0][i].dq  = side_i.num[i][CompW-1:0];
    end
    norm_c[0] = norm_i;
    side_c[0] = side_i;
    for (int s = 1; s < CompW; s++) begin
      st_c[s]   = st_q[s];
      norm_c[s] = norm_q[s];
      side_c[s] = side_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < CompW; s++) begin
      for (int i = 0; i < 3; i++) begin
        st_q[s+1][i] <= div_step(st_c[s][i], norm_c[s]);
      end
      norm_q[s+1] <= norm_c[s];
      side_q[s+1] <= side_c[s];
    end
  end

  // sign restore or pass-through
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side_q[CompW].clamp) begin
        res[i] = side_q[CompW].neg[i] ? (~st_q[CompW][i].dq + 1'b1) : st_q[CompW][i].dq;
      end else begin
        res[i] = side_q[CompW].raw[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.out_x       <= res[2];
    out_q.out_y       <= res[1];
    out_q.out_z       <= res[0];
    out_q.was_clamped <= side_q[CompW].clamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[CompW-1:1], vld_i};
      vld_out_q <= vld_q[CompW];
    end
  end

  assign vld_o = vld_out_q;
  assign out_o = out_q;

endmodule

// ===== rtl/vector_magnitude_clamp.sv =====
// Pipeline from start to done_o: squaring (stage A), then the norm and limit compare (stage B),
//   then the square root pipeline, the restoring divider pipeline and an output register.
// Throughput: one word per cycle; busy is always low and the receiver cannot stall.
// Reset (rst_ni, asynchronous): clears both limits and all valid bits in flight.
module vector_magnitude_clamp import vmc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  vmc_in_t         in_i,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [LimW-1:0] cfg_wdata_i,
  output logic            done_o,
  output vmc_out_t        out_o
);

  logic [LimW-1:0] vel_lim_q;
  logic [LimW-1:0] acc_lim_q;
  logic [LimW-1:0] lim;

  logic             f_vld;
  logic [SqW-1:0]   f_sq;
  vmc_side_t        f_side;
  logic             s_vld;
  logic [CompW-1:0] s_root;
  vmc_side_t        s_side;

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_lim_q <= '0;
      acc_lim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegVelocity: vel_lim_q <= cfg_wdata_i;
        RegAccel:    acc_lim_q <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  assign busy = 1'b0;
  assign lim  = in_i.command ? acc_lim_q : vel_lim_q;

  vmc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start),
    .in_i   (in_i),
    .lim_i  (lim),
    .vld_o  (f_vld),
    .sq_o   (f_sq),
    .side_o (f_side)
  );

  vmc_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (f_vld),
    .sq_i   (f_sq),
    .side_i (f_side),
    .vld_o  (s_vld),
    .root_o (s_root),
    .side_o (s_side)
  );

  vmc_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s_vld),
    .norm_i (s_root),
    .side_i (s_side),
    .vld_o  (done_o),
    .out_o  (out_o)
  );

endmodule

// ===== tb/vector_magnitude_clamp_tb.sv =====
module vector_magnitude_clamp_tb;
  import vmc_pkg::*;

  localparam int Latency  = 2 * CompW + 3;
  localparam int Watchdog = 4000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  vmc_in_t         in_i = '0;
  logic            cfg_we_i = 1'b0;
  logic            cfg_idx_i = 1'b0;
  logic [LimW-1:0] cfg_wdata_i = '0;
  logic            done_o;
  vmc_out_t        out_o;

  vector_magnitude_clamp DUT (.*);

  always #2 clk_i = ~clk_i;

  // limits as the predictor sees them
  logic [LimW-1:0] vel_lim, acc_lim;
  vmc_out_t        clamp_q[$];
  int              errors = 0;
  int              idle_cycles = 0;

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // expected limited vector for one input word
  function automatic vmc_out_t clamp_vector(vmc_in_t w);
    logic signed [CompW-1:0] c[3];
    logic [63:0] mag[3];
    logic [63:0] sq, lim, norm, q;
    vmc_out_t r;
    c[0] = w.comp_x; c[1] = w.comp_y; c[2] = w.comp_z;
    lim = w.command ? acc_lim : vel_lim;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i][CompW-1] ? 64'(-$signed(65'(c[i]))) : 64'(c[i]);
      sq += mag[i] * mag[i];
    end
    r = '0;
    if (sq > lim * lim) begin
      norm = floor_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] * lim) / norm;
        if (c[i][CompW-1]) q = -q;
        case (i)
          0: r.out_x = q[CompW-1:0];
          1: r.out_y = q[CompW-1:0];
          default: r.out_z = q[CompW-1:0];
        endcase
      end
      r.was_clamped = 1'b1;
    end else begin
      r.out_x = w.comp_x; r.out_y = w.comp_y; r.out_z = w.comp_z;
    end
    return r;
  endfunction

  // result check and watchdog
  always @(posedge clk_i) begin
    vmc_out_t want;
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done_o) begin
        if (clamp_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_o);
          errors++;
        end else begin
          want = clamp_q.pop_front();
          if (out_o.out_x !== want.out_x || out_o.out_y !== want.out_y ||
              out_o.out_z !== want.out_z || out_o.was_clamped !== want.was_clamped) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, out_o);
            errors++;
          end
        end
      end
      if (idle_cycles >= Watchdog) begin
        $display("vector_magnitude_clamp verification failed");
        $finish;
      end
    end
  end

  task automatic write_limit(vmc_reg_e idx, logic [LimW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == RegVelocity) vel_lim = val; else acc_lim = val;
  endtask

  // drive one word at the falling edge; held until accepted
  task automatic send_word(vmc_in_t w, bit has_exp, vmc_out_t exp_w);
    @(negedge clk_i);
    start = 1'b1; in_i = w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    clamp_q.push_back(has_exp ? exp_w : clamp_vector(w));
  endtask

  task automatic drain();
    @(negedge clk_i) start = 1'b0;
    while (clamp_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  function automatic logic signed [CompW-1:0] rand_comp(int big);
    if (big != 0) return CompW'($urandom);
    return CompW'($urandom_range(0, 2047)) - CompW'(1024);
  endfunction

  typedef struct {
    vmc_in_t  w;
    bit       has_exp;
    vmc_out_t exp_w;
  } stim_row_t;

  localparam logic signed [CompW-1:0] MaxC = 16'sh7fff;
  localparam logic signed [CompW-1:0] MinC = 16'sh8000;

  initial begin
    stim_row_t rows[$];
    vmc_in_t   w;
    int        burst;
    vel_lim = '0; acc_lim = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // zero limits after reset
    rows.push_back('{'{1'b0, 16'sd0, 16'sd0, 16'sd0}, 1, '{16'sd0, 16'sd0, 16'sd0, 1'b0}});
    rows.push_back('{'{1'b0, MaxC, MinC, 16'sd1}, 1, '{16'sd0, 16'sd0, 16'sd0, 1'b1}});
    rows.push_back('{'{1'b1, 16'sd5, -16'sd3, MinC}, 1, '{16'sd0, 16'sd0, 16'sd0, 1'b1}});
    foreach (rows[i]) send_word(rows[i].w, rows[i].has_exp, rows[i].exp_w);
    drain();

    // extreme limits, both commands
    write_limit(RegVelocity, 15'h7fff);
    write_limit(RegAccel, 15'd256);
    rows.delete();
    rows.push_back('{'{1'b0, MaxC, 16'sd0, 16'sd0}, 1, '{MaxC, 16'sd0, 16'sd0, 1'b0}});
    // norm floors to the limit: clamped but unchanged
    rows.push_back('{'{1'b0, MaxC, 16'sd1, 16'sd0}, 1, '{MaxC, 16'sd1, 16'sd0, 1'b1}});
    rows.push_back('{'{1'b1, 16'sd256, 16'sd0, 16'sd0}, 1, '{16'sd256, 16'sd0, 16'sd0, 1'b0}});
    rows.push_back('{'{1'b1, 16'sd257, 16'sd0, 16'sd0}, 1, '{16'sd256, 16'sd0, 16'sd0, 1'b1}});
    rows.push_back('{'{1'b1, MinC, MinC, MinC}, 0, '0});
    rows.push_back('{'{1'b0, MinC, MinC, MinC}, 0, '0});
    rows.push_back('{'{1'b1, -16'sd1, MaxC, -16'sd200}, 0, '0});
    rows.push_back('{'{1'b0, 16'sd100, -16'sd100, 16'sd100}, 0, '0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].has_exp, rows[i].exp_w);
    drain();

    // random phases with varied limits
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_limit(RegVelocity, 15'd0); write_limit(RegAccel, 15'h7fff); end
        1: begin write_limit(RegVelocity, 15'd1); write_limit(RegAccel, 15'd1); end
        default: begin
          write_limit(RegVelocity, LimW'($urandom_range(0, 2048)));
          write_limit(RegAccel, LimW'($urandom));
        end
      endcase
      for (int n = 0; n < 240; ) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < 240; b++, n++) begin
          w.command = 1'($urandom_range(0, 1));
          w.comp_x = rand_comp($urandom_range(0, 2));
          w.comp_y = rand_comp($urandom_range(0, 2));
          w.comp_z = rand_comp($urandom_range(0, 2));
          send_word(w, 0, '0);
        end
        @(negedge clk_i) start = 1'b0;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 40)) @(negedge clk_i);
      end
      drain();
    end

    if (errors == 0) $display("vector_magnitude_clamp verification clean");
    else $display("vector_magnitude_clamp verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vmc_pkg.sv
rtl/vmc_front.sv
rtl/vmc_sqrt_pipe.sv
rtl/vmc_div_pipe.sv
rtl/vector_magnitude_clamp.sv
tb/vector_magnitude_clamp_tb.sv
